FILE: src/clwfl_pkg.sv
`default_nettype none

package clwfl_pkg;

  // Number of cells in the store.
  localparam int unsigned CAPACITY = 16;
  // Bits to index one cell.
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  // Bits of a link: a cell index or the null code.
  localparam int unsigned PTR_W = $clog2(CAPACITY + 1);
  // A link that points nowhere holds the cell count.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_DELETE     = 2'd2,
    KIND_LIST       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_DEL_CMP,
    ST_DEL_FREE,
    ST_LIST
  } state_e;

endpackage

`default_nettype wire

FILE: src/cursor_list_with_free_list.sv
// Sequence: an insert at the front, an insert into a full store, or any operation on an
// empty list loads its result in ST_CMD, after the item is accepted in ST_IDLE. An insert
// at the end then steps through ST_WALK once per list element; a delete steps through
// ST_DEL_CMP once per element compared, then ST_DEL_FREE to free the cell; a listing
// loads one result per element in ST_LIST. The block works on one item at a time.
// Reset: the list is empty and the free list chains every cell in index order.
`default_nettype none

module cursor_list_with_free_list (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  // Result item.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] item
  output logic      [1:0]  m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast    // last
);

  import clwfl_pkg::*;

  // Sequencer state and the operation being worked on.
  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [VAL_W-1:0]   value_q, value_d;

  // Walk cursor, the cell before it, and the cell taken for an insert at the end.
  logic [PTR_W-1:0]   cur_q, cur_d;
  logic [PTR_W-1:0]   prev_q, prev_d;
  logic [PTR_W-1:0]   cell_q, cell_d;

  logic [PTR_W-1:0]   list_head_q, list_head_d;
  logic [PTR_W-1:0]   free_head_q, free_head_d;

  // Link store: flip-flops, since reset must chain the cells. One read and one
  // write port, used once per cycle.
  logic [PTR_W-1:0]   links_q [CAPACITY];
  logic               lk_we;
  logic [IDX_W-1:0]   lk_waddr;
  logic [PTR_W-1:0]   lk_wdata;
  logic [IDX_W-1:0]   lk_raddr;
  logic [PTR_W-1:0]   lk_rdata;

  // Value store. Its read address follows the next cursor, so the registered
  // read data always belongs to the cell under the current cursor.
  logic               val_we;
  logic [VAL_W-1:0]   val_rdata;

  // Output register.
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [VAL_W-1:0]   out_item_q, out_item_d;
  logic               out_last_q, out_last_d;
  logic               can_emit;
  logic               load;

  assign lk_rdata = links_q[lk_raddr];
  assign can_emit = !out_valid_q || m_axis_tready;

  clwfl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (free_head_q[IDX_W-1:0]),
    .wdata_i (value_q),
    .raddr_i (cur_d[IDX_W-1:0]),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      list_head_q <= NIL;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
      cur_q       <= NIL;
      prev_q      <= NIL;
      for (int i = 0; i < CAPACITY; i++) begin
        links_q[i] <= PTR_W'(i + 1);
      end
    end else begin
      state_q     <= state_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      if (lk_we) begin
        links_q[lk_waddr] <= lk_wdata;
      end
    end
  end

  // Payload registers carry no reset. The result payload changes only when a
  // new result is loaded, so a waiting result stays intact.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    cell_q  <= cell_d;
    if (load) begin
      out_status_q <= out_status_d;
      out_item_q   <= out_item_d;
      out_last_q   <= out_last_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    value_d      = value_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    cell_d       = cell_q;
    list_head_d  = list_head_q;
    free_head_d  = free_head_q;
    lk_we        = 1'b0;
    lk_waddr     = cur_q[IDX_W-1:0];
    lk_wdata     = NIL;
    lk_raddr     = cur_q[IDX_W-1:0];
    val_we       = 1'b0;
    load         = 1'b0;
    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_last_d   = out_last_q;

    // A single result for everything but a listing: zero item, marked last.
    out_status_d = STATUS_DONE;
    out_item_d   = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = kind_e'(s_axis_tuser);
          value_d = s_axis_tdata;
          state_d = ST_CMD;
        end
      end

      ST_CMD: begin
        // The link read in this state looks up the successor of the free head.
        lk_raddr = free_head_q[IDX_W-1:0];
        if (can_emit) begin
          unique case (kind_q)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (free_head_q == NIL) begin
                load         = 1'b1;
                out_status_d = STATUS_FULL;
                state_d      = ST_IDLE;
              end else begin
                // Take the cell at the front of the free list and fill it.
                val_we      = 1'b1;
                free_head_d = lk_rdata;
                lk_we       = 1'b1;
                lk_waddr    = free_head_q[IDX_W-1:0];
                if (kind_q == KIND_PUSH_FRONT) begin
                  lk_wdata    = list_head_q;
                  list_head_d = free_head_q;
                  load        = 1'b1;
                  state_d     = ST_IDLE;
                end else begin
                  lk_wdata = NIL;
                  if (list_head_q == NIL) begin
                    list_head_d = free_head_q;
                    load        = 1'b1;
                    state_d     = ST_IDLE;
                  end else begin
                    cur_d   = list_head_q;
                    cell_d  = free_head_q;
                    state_d = ST_WALK;
                  end
                end
              end
            end
            KIND_DELETE, KIND_LIST: begin
              if (list_head_q == NIL) begin
                load         = 1'b1;
                out_status_d = STATUS_EMPTY;
                state_d      = ST_IDLE;
              end else begin
                cur_d   = list_head_q;
                prev_d  = NIL;
                state_d = (kind_q == KIND_DELETE) ? ST_DEL_CMP : ST_LIST;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Step to the tail, then hook the new cell behind it.
      ST_WALK: begin
        if (lk_rdata == NIL) begin
          if (can_emit) begin
            lk_we    = 1'b1;
            lk_waddr = cur_q[IDX_W-1:0];
            lk_wdata = cell_q;
            load     = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          cur_d = lk_rdata;
        end
      end

      // Compare the cell under the cursor; on a match unlink it.
      ST_DEL_CMP: begin
        if (val_rdata == value_q) begin
          if (prev_q == NIL) begin
            list_head_d = lk_rdata;
          end else begin
            lk_we    = 1'b1;
            lk_waddr = prev_q[IDX_W-1:0];
            lk_wdata = lk_rdata;
          end
          state_d = ST_DEL_FREE;
        end else if (lk_rdata == NIL) begin
          if (can_emit) begin
            load         = 1'b1;
            out_status_d = STATUS_NOT_FOUND;
            state_d      = ST_IDLE;
          end
        end else begin
          prev_d = cur_q;
          cur_d  = lk_rdata;
        end
      end

      // Push the unlinked cell onto the front of the free list.
      ST_DEL_FREE: begin
        if (can_emit) begin
          lk_we       = 1'b1;
          lk_waddr    = cur_q[IDX_W-1:0];
          lk_wdata    = free_head_q;
          free_head_d = cur_q;
          load        = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // One result per element; the cell whose link is null is the last.
      ST_LIST: begin
        out_item_d = val_rdata;
        out_last_d = (lk_rdata == NIL);
        if (can_emit) begin
          load = 1'b1;
          if (lk_rdata == NIL) begin
            state_d = ST_IDLE;
          end else begin
            cur_d = lk_rdata;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // The list and the free list never start at the same cell.
  a_heads_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(list_head_q == free_head_q && list_head_q != NIL))
    else $error("list head and free head share a cell");

  // Once an item is taken, the block is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again right after an accept");

  // The final element of a listing ends the operation.
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST && load && lk_rdata == NIL |=> state_q == ST_IDLE)
    else $error("listing continued past its last element");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: src/clwfl_ram.sv
`default_nettype none

module clwfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
